@@ rtl/ptpadj_pkg.sv @@
`default_nettype none
package ptpadj_pkg;

    localparam logic [63:0] NS_PER_SEC = 64'd1000000000;
    localparam logic signed [63:0] PPB_LIMIT = 64'sd500000000;
    localparam logic signed [63:0] PPB_LIMIT_NEG = -64'sd500000000;
    localparam logic [63:0] PPM_TO_PPB = 64'd1000;
    localparam int PPM_FRAC_BITS = 16;

    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_SET    = 2'd1,
        OP_STEP   = 2'd2,
        OP_ADJUST = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        MUL_DRIFT,
        MUL_TARGET,
        MUL_PPM
    } mul_sel_t;

    typedef enum logic [1:0] {
        DIV_PROD,
        DIV_TOTAL,
        DIV_NOW
    } div_sel_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_MUL_DRIFT_WAIT,
        ST_DIV_DRIFT,
        ST_DIV_DRIFT_WAIT,
        ST_DRIFT_CAP,
        ST_SUM,
        ST_DIV_TOTAL,
        ST_DIV_TOTAL_WAIT,
        ST_TOTAL_CAP,
        ST_DIV_NOW,
        ST_DIV_NOW_WAIT,
        ST_EMIT_TIME,
        ST_MUL_TGT_WAIT,
        ST_SET,
        ST_STEP,
        ST_MUL_PPM,
        ST_MUL_PPM_WAIT,
        ST_ADJUST
    } state_t;

    typedef struct packed {
        logic     load;
        logic     mul_start;
        mul_sel_t mul_sel;
        logic     div_start;
        div_sel_t div_sel;
        logic     cap_drift;
        logic     cap_sum;
        logic     cap_total;
        logic     do_set;
        logic     do_step;
        logic     do_adjust;
        logic     emit_time;
        logic     emit_zero;
    } dp_cmd_t;

    typedef struct packed {
        op_t  opcode;
        logic mul_done;
        logic div_done;
    } dp_status_t;

endpackage
`default_nettype wire

@@ rtl/ptpadj_mul.sv @@
`default_nettype none
module ptpadj_mul
    import ptpadj_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] a,
    input  wire logic [63:0] b,
    output logic             done,
    output logic [63:0]      product
);

    // Low 64 bits of a 64x64 product from three 32x32 partial products,
    // one per clock; the high cross term falls outside the wrapped result.
    logic        busy_reg;
    logic        done_reg;
    logic [1:0]  cnt_reg;
    logic [63:0] a_reg;
    logic [63:0] b_reg;
    logic [63:0] pp_reg;
    logic [63:0] acc_reg;
    logic [31:0] op_x;
    logic [31:0] op_y;
    logic [63:0] pp_next;

    always_comb
    begin
        case (cnt_reg)
            2'd1:
            begin
                op_x = a_reg[31:0];
                op_y = b_reg[63:32];
            end
            2'd2:
            begin
                op_x = a_reg[63:32];
                op_y = b_reg[31:0];
            end
            default:
            begin
                op_x = a_reg[31:0];
                op_y = b_reg[31:0];
            end
        endcase
        pp_next = {32'd0, op_x} * {32'd0, op_y};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 2'd3);
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 2'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            a_reg <= a;
            b_reg <= b;
        end
        else if (busy_reg)
        begin
            pp_reg <= pp_next;
            case (cnt_reg)
                2'd1:    acc_reg <= pp_reg;
                2'd2:    acc_reg <= acc_reg + {pp_reg[31:0], 32'd0};
                2'd3:    acc_reg <= acc_reg + {pp_reg[31:0], 32'd0};
                default: acc_reg <= acc_reg;
            endcase
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule
`default_nettype wire

@@ rtl/ptpadj_div.sv @@
`default_nettype none
module ptpadj_div
    import ptpadj_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    output logic             done,
    output logic [63:0]      quotient,
    output logic [29:0]      remainder
);

    // Division by one second in nanoseconds through the reciprocal
    // floor(2^64 / 1e9) = 4 * 2^32 + RECIP_LO. The quotient taken from the
    // high product bits is low by at most one, which a single compare and
    // subtract on the remainder corrects. One step per clock: low partial
    // product, high partial product, quotient estimate, remainder, correction.
    localparam logic [2:0]  LAST     = 3'd4;
    localparam logic [31:0] RECIP_LO = 32'h4B82FA09;
    // 1e9 is NS_ODD * 2^9, so the low 31 bits of q * 1e9 need only the low
    // 22 bits of q * NS_ODD.
    localparam logic [21:0] NS_ODD   = 22'd1953125;
    localparam logic [30:0] DIVISOR  = NS_PER_SEC[30:0];

    logic        busy_reg;
    logic        done_reg;
    logic [2:0]  cnt_reg;
    logic [63:0] x_reg;
    logic [63:0] lo_reg;
    logic [63:0] hi_reg;
    logic [34:0] q_reg;
    logic [30:0] r_reg;
    logic [31:0] mul_x;
    logic [63:0] pp;
    logic [98:0] est_sum;
    logic [21:0] odd_prod;
    logic [30:0] r_diff;

    assign mul_x    = (cnt_reg == 3'd0) ? x_reg[31:0] : x_reg[63:32];
    assign pp       = {32'd0, mul_x} * {32'd0, RECIP_LO};
    assign est_sum  = {1'b0, x_reg, 34'd0} + {3'd0, hi_reg, 32'd0} + {35'd0, lo_reg};
    assign odd_prod = q_reg[21:0] * NS_ODD;
    // The true remainder is below 2^31, so the low bits of the difference
    // are exact.
    assign r_diff   = x_reg[30:0] - {odd_prod, 9'd0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == LAST);
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            x_reg <= dividend;
        end
        else if (busy_reg)
        begin
            case (cnt_reg)
                3'd0: lo_reg <= pp;
                3'd1: hi_reg <= pp;
                3'd2: q_reg  <= est_sum[98:64];
                3'd3: r_reg  <= r_diff;
                default:
                begin
                    if (r_reg >= DIVISOR)
                    begin
                        q_reg <= q_reg + 35'd1;
                        r_reg <= r_reg - DIVISOR;
                    end
                end
            endcase
        end
    end

    assign done      = done_reg;
    assign quotient  = {29'd0, q_reg};
    assign remainder = r_reg[29:0];

endmodule
`default_nettype wire

@@ rtl/ptpadj_dp.sv @@
`default_nettype none
module ptpadj_dp
    import ptpadj_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [1:0]         opcode,
    input  wire logic [62:0]        now_ns,
    input  wire logic [33:0]        target_sec,
    input  wire logic [29:0]        target_nsec,
    input  wire logic signed [63:0] step_delta_ns,
    input  wire logic signed [35:0] freq_adj_ppm,
    input  wire dp_cmd_t            cmd,
    output dp_status_t              status,
    output logic                    done,
    output logic                    is_time,
    output logic signed [34:0]      time_sec,
    output logic [29:0]             time_nsec
);

    // Clock state
    logic [63:0]        phase_reg, phase_next;
    logic signed [29:0] freq_reg, freq_next;
    logic [62:0]        ref_reg, ref_next;
    logic [63:0]        accum_reg, accum_next;

    // Item held for the duration of its processing
    op_t         op_reg;
    logic [62:0] now_reg;
    logic [33:0] tsec_reg;
    logic [29:0] tnsec_reg;
    logic [63:0] delta_reg;
    logic [35:0] sppm_reg;

    // Intermediate results
    logic [63:0] drift_reg;
    logic [63:0] total_reg;
    logic [34:0] sec_reg;
    logic [30:0] rem_reg;

    // Result registers
    logic        done_reg;
    logic        is_time_reg;
    logic [34:0] time_sec_reg;
    logic [29:0] time_nsec_reg;

    logic [63:0] mul_a, mul_b, mul_product;
    logic        mul_done;
    logic [63:0] div_dividend, div_quot;
    logic [29:0] div_rem;
    logic        div_done;

    logic [63:0] elapsed;
    logic [63:0] prod_mag;
    logic [63:0] total_mag;
    logic [63:0] ppb_full;
    logic [29:0] ppb_sat;
    logic [30:0] rem_pos;
    logic signed [31:0] nsec_sum;
    logic [34:0] sec_base;
    logic [31:0] nsec_fix;
    logic [34:0] sec_fix;

    assign elapsed   = {1'b0, now_reg} - {1'b0, ref_reg};
    assign prod_mag  = mul_product[63] ? (64'd0 - mul_product) : mul_product;
    assign total_mag = total_reg[63] ? (64'd0 - total_reg) : total_reg;
    assign rem_pos   = {1'b0, div_rem};

    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_TARGET:
            begin
                mul_a = {30'd0, tsec_reg};
                mul_b = NS_PER_SEC;
            end
            MUL_PPM:
            begin
                mul_a = {{28{sppm_reg[35]}}, sppm_reg};
                mul_b = PPM_TO_PPB;
            end
            default:
            begin
                mul_a = elapsed;
                mul_b = {{34{freq_reg[29]}}, freq_reg};
            end
        endcase
    end

    always_comb
    begin
        unique case (cmd.div_sel)
            DIV_TOTAL: div_dividend = total_mag;
            DIV_NOW:   div_dividend = {1'b0, now_reg};
            default:   div_dividend = prod_mag;
        endcase
    end

    ptpadj_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_product)
    );

    ptpadj_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // Frequency word: floor(ppm * 1000 / 2^16), clamped.
    always_comb
    begin
        ppb_full = {{PPM_FRAC_BITS{mul_product[63]}}, mul_product[63:PPM_FRAC_BITS]};
        if ($signed(ppb_full) > PPB_LIMIT)
        begin
            ppb_sat = PPB_LIMIT[29:0];
        end
        else if ($signed(ppb_full) < PPB_LIMIT_NEG)
        begin
            ppb_sat = PPB_LIMIT_NEG[29:0];
        end
        else
        begin
            ppb_sat = ppb_full[29:0];
        end
    end

    // Seconds and nanoseconds of now plus the signed offset, with one
    // borrow or carry to bring nanoseconds back into range.
    always_comb
    begin
        nsec_sum = $signed({2'b00, div_rem}) + $signed({rem_reg[30], rem_reg});
        sec_base = div_quot[34:0] + sec_reg;
        if (nsec_sum < 0)
        begin
            nsec_fix = 32'(nsec_sum) + NS_PER_SEC[31:0];
            sec_fix  = sec_base - 35'd1;
        end
        else if (32'(nsec_sum) >= NS_PER_SEC[31:0])
        begin
            nsec_fix = 32'(nsec_sum) - NS_PER_SEC[31:0];
            sec_fix  = sec_base + 35'd1;
        end
        else
        begin
            nsec_fix = 32'(nsec_sum);
            sec_fix  = sec_base;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        freq_next  = freq_reg;
        ref_next   = ref_reg;
        accum_next = accum_reg;
        if (cmd.do_set)
        begin
            phase_next = mul_product + {34'd0, tnsec_reg} - {1'b0, now_reg};
            ref_next   = now_reg;
            accum_next = '0;
        end
        else if (cmd.do_step)
        begin
            phase_next = phase_reg + delta_reg;
        end
        else if (cmd.do_adjust)
        begin
            accum_next = accum_reg + drift_reg;
            freq_next  = ppb_sat;
            ref_next   = now_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            freq_reg  <= '0;
            ref_reg   <= '0;
            accum_reg <= '0;
            op_reg    <= OP_READ;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            freq_reg  <= freq_next;
            ref_reg   <= ref_next;
            accum_reg <= accum_next;
            done_reg  <= cmd.emit_time || cmd.emit_zero;
            if (cmd.load)
            begin
                op_reg <= op_t'(opcode);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            now_reg   <= now_ns;
            tsec_reg  <= target_sec;
            tnsec_reg <= target_nsec;
            delta_reg <= step_delta_ns;
            sppm_reg  <= freq_adj_ppm;
        end
        if (cmd.cap_drift)
        begin
            drift_reg <= mul_product[63] ? (64'd0 - div_quot) : div_quot;
        end
        if (cmd.cap_sum)
        begin
            total_reg <= phase_reg + accum_reg + drift_reg;
        end
        if (cmd.cap_total)
        begin
            sec_reg <= total_reg[63] ? (35'd0 - div_quot[34:0]) : div_quot[34:0];
            rem_reg <= total_reg[63] ? (31'd0 - rem_pos) : rem_pos;
        end
        if (cmd.emit_time)
        begin
            is_time_reg   <= 1'b1;
            time_sec_reg  <= sec_fix;
            time_nsec_reg <= nsec_fix[29:0];
        end
        else if (cmd.emit_zero)
        begin
            is_time_reg   <= 1'b0;
            time_sec_reg  <= '0;
            time_nsec_reg <= '0;
        end
    end

    assign status.opcode   = op_reg;
    assign status.mul_done = mul_done;
    assign status.div_done = div_done;

    assign done      = done_reg;
    assign is_time   = is_time_reg;
    assign time_sec  = $signed(time_sec_reg);
    assign time_nsec = time_nsec_reg;

endmodule
`default_nettype wire

@@ rtl/ptpadj_ctrl.sv @@
`default_nettype none
module ptpadj_ctrl
    import ptpadj_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire dp_status_t status,
    output logic            busy,
    output dp_cmd_t         cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                unique case (status.opcode) inside
                    OP_SET:  state_next = ST_MUL_TGT_WAIT;
                    OP_STEP: state_next = ST_STEP;
                    default: state_next = ST_MUL_DRIFT_WAIT;
                endcase
            end
            ST_MUL_DRIFT_WAIT:
            begin
                if (status.mul_done)
                begin
                    state_next = ST_DIV_DRIFT;
                end
            end
            ST_DIV_DRIFT:      state_next = ST_DIV_DRIFT_WAIT;
            ST_DIV_DRIFT_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = ST_DRIFT_CAP;
                end
            end
            ST_DRIFT_CAP:
            begin
                if (status.opcode == OP_ADJUST)
                begin
                    state_next = ST_MUL_PPM;
                end
                else
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:            state_next = ST_DIV_TOTAL;
            ST_DIV_TOTAL:      state_next = ST_DIV_TOTAL_WAIT;
            ST_DIV_TOTAL_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = ST_TOTAL_CAP;
                end
            end
            ST_TOTAL_CAP:      state_next = ST_DIV_NOW;
            ST_DIV_NOW:        state_next = ST_DIV_NOW_WAIT;
            ST_DIV_NOW_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = ST_EMIT_TIME;
                end
            end
            ST_EMIT_TIME:      state_next = ST_IDLE;
            ST_MUL_TGT_WAIT:
            begin
                if (status.mul_done)
                begin
                    state_next = ST_SET;
                end
            end
            ST_SET:            state_next = ST_IDLE;
            ST_STEP:           state_next = ST_IDLE;
            ST_MUL_PPM:        state_next = ST_MUL_PPM_WAIT;
            ST_MUL_PPM_WAIT:
            begin
                if (status.mul_done)
                begin
                    state_next = ST_ADJUST;
                end
            end
            ST_ADJUST:         state_next = ST_IDLE;
            default:           state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.mul_sel = MUL_DRIFT;
        cmd.div_sel = DIV_PROD;
        unique case (state_reg)
            ST_IDLE:      cmd.load = start;
            ST_DISPATCH:
            begin
                cmd.mul_start = (status.opcode != OP_STEP);
                if (status.opcode == OP_SET)
                begin
                    cmd.mul_sel = MUL_TARGET;
                end
            end
            ST_DIV_DRIFT: cmd.div_start = 1'b1;
            ST_DRIFT_CAP: cmd.cap_drift = 1'b1;
            ST_SUM:       cmd.cap_sum = 1'b1;
            ST_DIV_TOTAL:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_TOTAL;
            end
            ST_DIV_TOTAL_WAIT: cmd.div_sel = DIV_TOTAL;
            ST_TOTAL_CAP: cmd.cap_total = 1'b1;
            ST_DIV_NOW:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_NOW;
            end
            ST_DIV_NOW_WAIT: cmd.div_sel = DIV_NOW;
            ST_EMIT_TIME: cmd.emit_time = 1'b1;
            ST_MUL_TGT_WAIT: cmd.mul_sel = MUL_TARGET;
            ST_SET:
            begin
                cmd.do_set    = 1'b1;
                cmd.emit_zero = 1'b1;
            end
            ST_STEP:
            begin
                cmd.do_step   = 1'b1;
                cmd.emit_zero = 1'b1;
            end
            ST_MUL_PPM:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_PPM;
            end
            ST_MUL_PPM_WAIT: cmd.mul_sel = MUL_PPM;
            ST_ADJUST:
            begin
                cmd.mul_sel   = MUL_PPM;
                cmd.do_adjust = 1'b1;
                cmd.emit_zero = 1'b1;
            end
            default:
            begin
                cmd.load = 1'b0;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule
`default_nettype wire

@@ rtl/ptp_clock_offset_freq_adjust.sv @@
`default_nettype none
// Adjustable time-of-day clock built on a free-running nanosecond reference.
// A command is transferred on a rising edge with start high and busy low;
// it carries the opcode, the current reference time and the operand of its
// opcode (target time, step delta or scaled ppm). busy stays high until the
// command has finished. Every command produces exactly one result: done is
// high for one cycle with is_time, time_sec and time_nsec. Only a read
// returns a time; set, step and frequency adjust return zeros.
// A new command can be transferred in the cycle done is high. A read makes
// one pass through the 32x32 multiplier sequence for the drift and three
// passes through the shared divide-by-1e9 unit; adjust makes two multiplier
// passes and one divide; set makes one multiplier pass.
// The receiver cannot stall: done is a strobe that must be taken when it
// appears. Reset clears the offset, frequency, reference instant and
// accumulated drift to zero and returns the block to idle.
module ptp_clock_offset_freq_adjust
    import ptpadj_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         opcode,
    input  wire logic [62:0]        now_ns,
    input  wire logic [33:0]        target_sec,
    input  wire logic [29:0]        target_nsec,
    input  wire logic signed [63:0] step_delta_ns,
    input  wire logic signed [35:0] freq_adj_ppm,
    output logic                    done,
    output logic                    is_time,
    output logic signed [34:0]      time_sec,
    output logic [29:0]             time_nsec
);

    dp_cmd_t    cmd;
    dp_status_t status;

    ptpadj_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    ptpadj_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .opcode        (opcode),
        .now_ns        (now_ns),
        .target_sec    (target_sec),
        .target_nsec   (target_nsec),
        .step_delta_ns (step_delta_ns),
        .freq_adj_ppm  (freq_adj_ppm),
        .cmd           (cmd),
        .status        (status),
        .done          (done),
        .is_time       (is_time),
        .time_sec      (time_sec),
        .time_nsec     (time_nsec)
    );

endmodule
`default_nettype wire

@@ rtl/ptpadj_checker.sv @@
`default_nettype none
module ptpadj_checker
    import ptpadj_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               done,
    input wire logic               is_time,
    input wire logic signed [34:0] time_sec,
    input wire logic [29:0]        time_nsec
);

    // A transfer always puts the block to work.
    a_transfer_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after a command transfer");

    // busy only rises as the result of a transfer.
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a command transfer");

    // A result is delivered only once the command has finished.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while still busy");

    // Results never abut: done is never held high from one result into the next.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    // Read times carry normalized nanoseconds.
    a_nsec_range: assert property (@(posedge clk) disable iff (!rst_n)
        done && is_time |-> ({34'd0, time_nsec} < NS_PER_SEC))
        else $error("nanoseconds out of range in read result");

endmodule

bind ptp_clock_offset_freq_adjust ptpadj_checker u_ptpadj_checker (.*);
`default_nettype wire
